>>> hdl/bilinear_wrap_texture_sampler_unit_macros.svh
// ----------------------------------------------------------------------------
// Bilinear wrap texture sampler: assertion macros
// Shared concurrent assertion forms, reset-qualified on rst_n.
// ----------------------------------------------------------------------------
`ifndef BILINEAR_WRAP_TEXTURE_SAMPLER_UNIT_MACROS_SVH
`define BILINEAR_WRAP_TEXTURE_SAMPLER_UNIT_MACROS_SVH

// Same-cycle implication
`define BWTS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bwts assertion failed");

// Next-cycle implication
`define BWTS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bwts assertion failed");

`endif

>>> hdl/bwts_pkg.sv
// ----------------------------------------------------------------------------
// Bilinear wrap texture sampler: package
// Shared types, mode codes and default texture size.
// ----------------------------------------------------------------------------
package bwts_pkg;

    // Default texture side in texels
    localparam int TEXTURE_SIDE_DEF = 512;

    // Item mode codes
    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_SAMPLE = 1'b1;

    // One stored texel, green in the high byte
    typedef struct packed {
        logic [7:0] green;
        logic [7:0] red;
    } texel_t;

    // 2x2 neighbourhood: row y0 (t00, t01) and row y1 (t10, t11)
    typedef struct packed {
        texel_t t00;
        texel_t t01;
        texel_t t10;
        texel_t t11;
    } quad_t;

    // 7-bit fractional blend weights
    typedef struct packed {
        logic [6:0] fx;
        logic [6:0] fy;
    } weight_t;

endpackage

>>> hdl/bilinear_wrap_texture_sampler_unit.sv
// ----------------------------------------------------------------------------
// Bilinear wrap texture sampler unit
// Texture store with repeat-wrapped bilinear filtering of two 8-bit channels.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one beat per item. mode selects
//   a texel write (no result) or a bilinear sample (one result beat on the
//   out_valid/out_ready channel, values in units of 1/128 code).
//   Pipeline: coordinate scaling, texel store read, row blend, column blend
//   into the output register. One item is accepted every cycle while the
//   receiver keeps out_ready high.
//   The four neighbours come from two copies of the texture (one per row),
//   each read at two addresses per cycle; writes go to both copies at the
//   same pipeline point as reads, so a sample sees every earlier write.
//   Reset empties the pipeline; texture contents are undefined until written.
//   When the receiver stalls, beats stay in the pipeline registers and
//   in_ready drops only once every stage holds a beat.
// ----------------------------------------------------------------------------
`include "bilinear_wrap_texture_sampler_unit_macros.svh"

module bilinear_wrap_texture_sampler_unit #(
    parameter int TEXTURE_SIDE = bwts_pkg::TEXTURE_SIDE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic [15:0] u_coord,
    input  logic [15:0] v_coord,
    input  logic [7:0]  texel_red,
    input  logic [7:0]  texel_green,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [14:0] red_sample,
    output logic [14:0] green_sample
);

    localparam int IW = $clog2(TEXTURE_SIDE);

    logic               s1_valid;
    logic               s1_mode;
    logic [IW-1:0]      s1_x0;
    logic [IW-1:0]      s1_x1;
    logic [IW-1:0]      s1_y0;
    logic [IW-1:0]      s1_y1;
    bwts_pkg::weight_t  s1_weight;
    bwts_pkg::texel_t   s1_texel;
    logic               s1_fire;
    logic               wr_en;
    logic               rd_en;
    logic               s2_ready;
    logic               s2_valid_reg;
    bwts_pkg::weight_t  s2_weight_reg;
    bwts_pkg::quad_t    s2_quad;
    logic               s3_ready;

    // Coordinate stage
    bwts_coord #(
        .TEXTURE_SIDE (TEXTURE_SIDE)
    ) u_coord_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .u_coord     (u_coord),
        .v_coord     (v_coord),
        .texel_red   (texel_red),
        .texel_green (texel_green),
        .s1_valid    (s1_valid),
        .s1_ready    (s2_ready),
        .s1_mode     (s1_mode),
        .s1_x0       (s1_x0),
        .s1_x1       (s1_x1),
        .s1_y0       (s1_y0),
        .s1_y1       (s1_y1),
        .s1_weight   (s1_weight),
        .s1_texel    (s1_texel)
    );

    // Store access as the coordinate beat moves on
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_fire  = s1_valid && s2_ready;
    assign wr_en    = s1_fire && (s1_mode == bwts_pkg::MODE_WRITE);
    assign rd_en    = s1_fire && (s1_mode == bwts_pkg::MODE_SAMPLE);

    bwts_texel_store #(
        .TEXTURE_SIDE (TEXTURE_SIDE)
    ) u_store (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   ({s1_y0, s1_x0}),
        .wr_data   (s1_texel),
        .rd_en     (rd_en),
        .rd_addr00 ({s1_y0, s1_x0}),
        .rd_addr01 ({s1_y0, s1_x1}),
        .rd_addr10 ({s1_y1, s1_x0}),
        .rd_addr11 ({s1_y1, s1_x1}),
        .rd_quad   (s2_quad)
    );

    // Read stage valid and weights; writes leave no beat behind
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= rd_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            s2_weight_reg <= s1_weight;
        end
    end

    // Blend and output
    bwts_blend u_blend (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s2_valid_reg),
        .in_ready     (s3_ready),
        .quad         (s2_quad),
        .weight       (s2_weight_reg),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .red_sample   (red_sample),
        .green_sample (green_sample)
    );

    `BWTS_ASSERT_NEXT(a_write_no_beat, wr_en, !s2_valid_reg)
    `BWTS_ASSERT_NEXT(a_sample_reaches_read, rd_en, s2_valid_reg)
    `BWTS_ASSERT_NOW(a_stall_only_when_full, !in_ready, s1_valid && s2_valid_reg && out_valid && !out_ready)

endmodule

>>> hdl/bwts_coord.sv
// ----------------------------------------------------------------------------
// Bilinear wrap texture sampler: coordinate stage
// Scales 0.16 coordinates to texel indices and weights, registers the beat.
// ----------------------------------------------------------------------------
module bwts_coord #(
    parameter int TEXTURE_SIDE = bwts_pkg::TEXTURE_SIDE_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                mode,
    input  logic [15:0]                         u_coord,
    input  logic [15:0]                         v_coord,
    input  logic [7:0]                          texel_red,
    input  logic [7:0]                          texel_green,
    output logic                                s1_valid,
    input  logic                                s1_ready,
    output logic                                s1_mode,
    output logic [$clog2(TEXTURE_SIDE)-1:0]     s1_x0,
    output logic [$clog2(TEXTURE_SIDE)-1:0]     s1_x1,
    output logic [$clog2(TEXTURE_SIDE)-1:0]     s1_y0,
    output logic [$clog2(TEXTURE_SIDE)-1:0]     s1_y1,
    output bwts_pkg::weight_t                   s1_weight,
    output bwts_pkg::texel_t                    s1_texel
);

    localparam int IW = $clog2(TEXTURE_SIDE);
    localparam int SW = 16 + IW;

    logic [SW-1:0]       su;
    logic [SW-1:0]       sv;
    logic                accept;
    logic                valid_reg;
    logic                mode_reg;
    logic [IW-1:0]       x0_reg;
    logic [IW-1:0]       y0_reg;
    bwts_pkg::weight_t   weight_reg;
    bwts_pkg::texel_t    texel_reg;

    // Scaled coordinates, 16 fraction bits
    assign su = SW'(u_coord) * SW'(TEXTURE_SIDE);
    assign sv = SW'(v_coord) * SW'(TEXTURE_SIDE);

    assign in_ready = !valid_reg || s1_ready;
    assign accept   = in_valid && in_ready;

    // Stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg        <= mode;
            x0_reg          <= su[SW-1:16];
            y0_reg          <= sv[SW-1:16];
            weight_reg.fx   <= su[15:9];
            weight_reg.fy   <= sv[15:9];
            texel_reg.red   <= texel_red;
            texel_reg.green <= texel_green;
        end
    end

    // Right and lower neighbours wrap to zero past the last texel
    assign s1_x1 = (x0_reg == IW'(TEXTURE_SIDE - 1)) ? '0 : x0_reg + 1'b1;
    assign s1_y1 = (y0_reg == IW'(TEXTURE_SIDE - 1)) ? '0 : y0_reg + 1'b1;

    assign s1_valid  = valid_reg;
    assign s1_mode   = mode_reg;
    assign s1_x0     = x0_reg;
    assign s1_y0     = y0_reg;
    assign s1_weight = weight_reg;
    assign s1_texel  = texel_reg;

endmodule

>>> hdl/bwts_texel_store.sv
// ----------------------------------------------------------------------------
// Bilinear wrap texture sampler: texel store
// Two identical copies of the texture, one per neighbour row, each with one
// write port and two registered read ports.
// ----------------------------------------------------------------------------
module bwts_texel_store #(
    parameter int TEXTURE_SIDE = bwts_pkg::TEXTURE_SIDE_DEF
) (
    input  logic                                clk,
    input  logic                                wr_en,
    input  logic [2*$clog2(TEXTURE_SIDE)-1:0]   wr_addr,
    input  bwts_pkg::texel_t                    wr_data,
    input  logic                                rd_en,
    input  logic [2*$clog2(TEXTURE_SIDE)-1:0]   rd_addr00,
    input  logic [2*$clog2(TEXTURE_SIDE)-1:0]   rd_addr01,
    input  logic [2*$clog2(TEXTURE_SIDE)-1:0]   rd_addr10,
    input  logic [2*$clog2(TEXTURE_SIDE)-1:0]   rd_addr11,
    output bwts_pkg::quad_t                     rd_quad
);

    localparam int AW    = 2 * $clog2(TEXTURE_SIDE);
    localparam int DEPTH = 1 << AW;

    bwts_pkg::texel_t row0_mem [0:DEPTH-1];
    bwts_pkg::texel_t row1_mem [0:DEPTH-1];
    bwts_pkg::quad_t  quad_reg;

    // Writes land in both copies
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            row0_mem[wr_addr] <= wr_data;
            row1_mem[wr_addr] <= wr_data;
        end
    end

    // Upper row from one copy, lower row from the other
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            quad_reg.t00 <= row0_mem[rd_addr00];
            quad_reg.t01 <= row0_mem[rd_addr01];
            quad_reg.t10 <= row1_mem[rd_addr10];
            quad_reg.t11 <= row1_mem[rd_addr11];
        end
    end

    assign rd_quad = quad_reg;

endmodule

>>> hdl/bwts_blend.sv
// ----------------------------------------------------------------------------
// Bilinear wrap texture sampler: blend pipeline
// Row blend across x, then column blend across y into the output register.
// ----------------------------------------------------------------------------
module bwts_blend (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  bwts_pkg::quad_t    quad,
    input  bwts_pkg::weight_t  weight,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [14:0]        red_sample,
    output logic [14:0]        green_sample
);

    // a*(128-f) + b*f, exact, at most 32640
    function automatic logic [14:0] row_blend(input logic [7:0] a, input logic [7:0] b,
                                              input logic [6:0] f);
        logic [7:0]  wl;
        logic [15:0] acc;
        wl  = 8'd128 - {1'b0, f};
        acc = 16'(a) * 16'(wl) + 16'(b) * 16'(f);
        return acc[14:0];
    endfunction

    // (r0*(128-f) + r1*f) >> 7, truncated
    function automatic logic [14:0] col_blend(input logic [14:0] r0, input logic [14:0] r1,
                                              input logic [6:0] f);
        logic [7:0]  wl;
        logic [21:0] acc;
        wl  = 8'd128 - {1'b0, f};
        acc = 22'(r0) * 22'(wl) + 22'(r1) * 22'(f);
        return acc[21:7];
    endfunction

    logic        s3_ready;
    logic        s3_valid_reg;
    logic [14:0] red_r0_reg;
    logic [14:0] red_r1_reg;
    logic [14:0] grn_r0_reg;
    logic [14:0] grn_r1_reg;
    logic [6:0]  fy_reg;
    logic        out_valid_reg;
    logic [14:0] red_reg;
    logic [14:0] grn_reg;

    assign s3_ready = !out_valid_reg || out_ready;
    assign in_ready = !s3_valid_reg || s3_ready;

    // Row blend stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s3_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            red_r0_reg <= row_blend(quad.t00.red,   quad.t01.red,   weight.fx);
            red_r1_reg <= row_blend(quad.t10.red,   quad.t11.red,   weight.fx);
            grn_r0_reg <= row_blend(quad.t00.green, quad.t01.green, weight.fx);
            grn_r1_reg <= row_blend(quad.t10.green, quad.t11.green, weight.fx);
            fy_reg     <= weight.fy;
        end
    end

    // Column blend into the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s3_ready)
        begin
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_valid_reg && s3_ready)
        begin
            red_reg <= col_blend(red_r0_reg, red_r1_reg, fy_reg);
            grn_reg <= col_blend(grn_r0_reg, grn_r1_reg, fy_reg);
        end
    end

    assign out_valid    = out_valid_reg;
    assign red_sample   = red_reg;
    assign green_sample = grn_reg;

endmodule

>>> verif/bilinear_wrap_texture_sampler_unit_tb.sv
// ----------------------------------------------------------------------------
// Bilinear wrap texture sampler unit: testbench
// Writes small texel tiles (some across the wrap edges) and samples inside
// them. A scoreboard filters the same neighbourhood from a mirror of the
// texture and checks each result beat in order. Both channels are throttled
// at random, apart from one full-rate stretch.
// ----------------------------------------------------------------------------
module bilinear_wrap_texture_sampler_unit_tb;

    localparam int SIDE    = bwts_pkg::TEXTURE_SIDE_DEF;
    localparam int ENTRIES = SIDE * SIDE;

    typedef struct packed {
        logic [14:0] red;
        logic [14:0] green;
    } filtered_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        mode;
    logic [15:0] u_coord;
    logic [15:0] v_coord;
    logic [7:0]  texel_red;
    logic [7:0]  texel_green;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [14:0] red_sample;
    logic [14:0] green_sample;

    // Mirror of the texture and which texels / 2x2 anchors are safe to read
    bwts_pkg::texel_t texture_mirror [ENTRIES];
    bit               texel_written  [ENTRIES];
    bit               anchor_marked  [ENTRIES];
    int unsigned      anchor_list    [$];

    filtered_t   pending_samples [$];

    bit          steady = 1'b0;
    int unsigned beats_sent;
    int unsigned writes_sent;
    int unsigned samples_sent;
    int unsigned wrap_samples;
    int unsigned results_checked;
    int unsigned mismatch_count;

    bilinear_wrap_texture_sampler_unit #(
        .TEXTURE_SIDE (SIDE)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .u_coord      (u_coord),
        .v_coord      (v_coord),
        .texel_red    (texel_red),
        .texel_green  (texel_green),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .red_sample   (red_sample),
        .green_sample (green_sample)
    );

    always #2 clk = ~clk;

    // Receiver throttle
    always @(posedge clk)
    begin
        out_ready <= steady || ($urandom_range(0, 99) >= 20);
    end

    // Texel index plus a 7-bit fraction of one texel, in 0.16 units
    function automatic logic [15:0] coord_of(int unsigned idx, int unsigned frac);
        return 16'((idx * 65536 + frac * 512) / SIDE);
    endfunction

    function automatic int unsigned wrap_inc(int unsigned i);
        return (i + 1 >= SIDE) ? 0 : i + 1;
    endfunction

    // One channel: exact row blends, truncated column blend
    function automatic logic [14:0] mix_channel(int unsigned a, int unsigned b,
                                                int unsigned c, int unsigned d,
                                                int unsigned fx, int unsigned fy);
        int unsigned r0;
        int unsigned r1;
        r0 = a * (128 - fx) + b * fx;
        r1 = c * (128 - fx) + d * fx;
        return 15'((r0 * (128 - fy) + r1 * fy) >> 7);
    endfunction

    function automatic filtered_t filter_at(logic [15:0] u, logic [15:0] v);
        int unsigned      su;
        int unsigned      sv;
        int unsigned      x0;
        int unsigned      y0;
        int unsigned      x1;
        int unsigned      y1;
        bwts_pkg::texel_t q00;
        bwts_pkg::texel_t q01;
        bwts_pkg::texel_t q10;
        bwts_pkg::texel_t q11;
        filtered_t        res;
        su  = u * SIDE;
        sv  = v * SIDE;
        x0  = su >> 16;
        y0  = sv >> 16;
        x1  = wrap_inc(x0);
        y1  = wrap_inc(y0);
        q00 = texture_mirror[y0 * SIDE + x0];
        q01 = texture_mirror[y0 * SIDE + x1];
        q10 = texture_mirror[y1 * SIDE + x0];
        q11 = texture_mirror[y1 * SIDE + x1];
        res.red   = mix_channel(q00.red, q01.red, q10.red, q11.red,
                                (su >> 9) & 127, (sv >> 9) & 127);
        res.green = mix_channel(q00.green, q01.green, q10.green, q11.green,
                                (su >> 9) & 127, (sv >> 9) & 127);
        return res;
    endfunction

    // Store a texel and register any 2x2 neighbourhood it completes
    function automatic void store_texel(logic [15:0] u, logic [15:0] v,
                                        logic [7:0] r, logic [7:0] g);
        int unsigned x;
        int unsigned y;
        int unsigned ax;
        int unsigned ay;
        int unsigned a;
        x = (u * SIDE) >> 16;
        y = (v * SIDE) >> 16;
        texture_mirror[y * SIDE + x] = '{green: g, red: r};
        texel_written[y * SIDE + x]  = 1'b1;
        for (int dy = 0; dy < 2; dy++)
        begin
            for (int dx = 0; dx < 2; dx++)
            begin
                ax = (x + SIDE - dx) % SIDE;
                ay = (y + SIDE - dy) % SIDE;
                a  = ay * SIDE + ax;
                if (!anchor_marked[a] && texel_written[a]
                    && texel_written[ay * SIDE + wrap_inc(ax)]
                    && texel_written[wrap_inc(ay) * SIDE + ax]
                    && texel_written[wrap_inc(ay) * SIDE + wrap_inc(ax)])
                begin
                    anchor_marked[a] = 1'b1;
                    anchor_list.insert(anchor_list.size(), a);
                end
            end
        end
    endfunction

    function automatic void note_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] MISMATCH %s", $realtime, what);
    endfunction

    // Result checker
    always @(posedge clk)
    begin : check_results
        filtered_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            if (pending_samples.size() == 0)
            begin
                note_mismatch($sformatf("unexpected beat red=%0d green=%0d",
                                        red_sample, green_sample));
            end
            else
            begin
                want = pending_samples.pop_front();
                results_checked++;
                if (red_sample !== want.red)
                    note_mismatch($sformatf("red expected %0d got %0d",
                                            want.red, red_sample));
                if (green_sample !== want.green)
                    note_mismatch($sformatf("green expected %0d got %0d",
                                            want.green, green_sample));
            end
        end
    end

    // Send one beat, with random idle cycles ahead of it
    task automatic send_beat(input logic m, input logic [15:0] u, input logic [15:0] v,
                             input logic [7:0] r, input logic [7:0] g);
        int unsigned su;
        int unsigned sv;
        while (!steady && $urandom_range(0, 99) < 20)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        mode        <= m;
        u_coord     <= u;
        v_coord     <= v;
        texel_red   <= r;
        texel_green <= g;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
        beats_sent++;
        if (m == bwts_pkg::MODE_WRITE)
        begin
            writes_sent++;
            store_texel(u, v, r, g);
        end
        else
        begin
            samples_sent++;
            su = u * SIDE;
            sv = v * SIDE;
            if ((su >> 16) == SIDE - 1 || (sv >> 16) == SIDE - 1)
                wrap_samples++;
            pending_samples.insert(pending_samples.size(), filter_at(u, v));
        end
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic int unsigned pick_frac();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 127;
            default: return $urandom_range(0, 127);
        endcase
    endfunction

    task automatic write_texel(input int unsigned x, input int unsigned y,
                               input logic [7:0] r, input logic [7:0] g);
        send_beat(bwts_pkg::MODE_WRITE, coord_of(x, $urandom_range(0, 127)),
                  coord_of(y, $urandom_range(0, 127)), r, g);
    endtask

    task automatic sample_at(input int unsigned x, input int unsigned y,
                             input int unsigned fx, input int unsigned fy);
        send_beat(bwts_pkg::MODE_SAMPLE, coord_of(x, fx), coord_of(y, fy),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    task automatic sample_any_anchor();
        int unsigned a;
        a = anchor_list[$urandom_range(0, anchor_list.size() - 1)];
        sample_at(a % SIDE, a / SIDE, pick_frac(), pick_frac());
    endtask

    // Write a tile, then sample inside it and at other written neighbourhoods, mixed with overwrites and stray writes
    task automatic run_tile(input int unsigned max_size);
        int unsigned bx;
        int unsigned by;
        int unsigned w;
        int unsigned h;
        int unsigned a;
        int unsigned x;
        int unsigned y;
        bx = ($urandom_range(0, 3) == 0) ? $urandom_range(SIDE - 3, SIDE - 1)
                                         : $urandom_range(0, SIDE - 1);
        by = ($urandom_range(0, 3) == 0) ? $urandom_range(SIDE - 3, SIDE - 1)
                                         : $urandom_range(0, SIDE - 1);
        w  = $urandom_range(2, max_size);
        h  = $urandom_range(2, max_size);
        for (int j = 0; j < h; j++)
            for (int i = 0; i < w; i++)
                write_texel((bx + i) % SIDE, (by + j) % SIDE, pick_byte(), pick_byte());
        repeat (w * h * 2)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    // overwrite one corner of a neighbourhood, then read it at once
                    a = anchor_list[$urandom_range(0, anchor_list.size() - 1)];
                    x = a % SIDE;
                    y = a / SIDE;
                    write_texel((x + $urandom_range(0, 1)) % SIDE,
                                (y + $urandom_range(0, 1)) % SIDE,
                                pick_byte(), pick_byte());
                    sample_at(x, y, pick_frac(), pick_frac());
                end
                1:
                    write_texel($urandom_range(0, SIDE - 1), $urandom_range(0, SIDE - 1),
                                pick_byte(), pick_byte());
                2:
                    sample_any_anchor();
                default:
                    sample_at((bx + $urandom_range(0, w - 2)) % SIDE,
                              (by + $urandom_range(0, h - 2)) % SIDE,
                              pick_frac(), pick_frac());
            endcase
        end
    endtask

    // Lower valid and hold off until every expected result has arrived
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_samples.size() != 0);
    endtask

    // Directed: 4x4 block around the corner where both axes wrap
    task automatic test_edge_wrap();
        int unsigned edges [4];
        edges = '{SIDE - 2, SIDE - 1, 0, 1};
        for (int j = 0; j < 4; j++)
            for (int i = 0; i < 4; i++)
                write_texel(edges[i], edges[j],
                            ((i + j) % 2) ? 8'hFF : 8'h00,
                            ((i + j) % 2) ? 8'h00 : 8'hFF);
        sample_at(SIDE - 1, SIDE - 1, 0, 0);      // whole coordinates at the corner
        sample_at(SIDE - 1, SIDE - 1, 127, 127);  // largest coordinates, both wrap
        sample_at(0, 0, 64, 64);
        sample_at(SIDE - 1, 0, 127, 0);           // wrap across x only
        sample_at(0, SIDE - 1, 0, 127);           // wrap across y only
        sample_at(0, 0, 0, 0);                    // zero coordinates
        sample_at(SIDE - 2, SIDE - 2, 1, 127);
        write_texel(SIDE - 1, 0, 8'hFF, 8'hFF);   // write then read straight away
        sample_at(SIDE - 1, 0, 0, 0);
    endtask

    task automatic test_tile_sampling(input int unsigned until_beats);
        while (beats_sent < until_beats)
            run_tile(4);
    endtask

    task automatic test_full_rate(input int unsigned until_beats);
        drain_results();
        steady = 1'b1;
        while (beats_sent < until_beats)
            run_tile(4);
        steady = 1'b0;
    endtask

    task automatic test_mixed_traffic(input int unsigned until_beats);
        while (beats_sent < until_beats)
        begin
            if ($urandom_range(0, 4) == 0)
                run_tile(8);
            else
                run_tile(3);
        end
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        mode        <= bwts_pkg::MODE_WRITE;
        u_coord     <= '0;
        v_coord     <= '0;
        texel_red   <= '0;
        texel_green <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_edge_wrap();
        test_tile_sampling(700);
        test_full_rate(1000);
        test_mixed_traffic(1350);

        drain_results();
        repeat (20) @(posedge clk);
        $display("Run covered %0d writes and %0d samples (%0d at a wrap edge)",
                 writes_sent, samples_sent, wrap_samples);
        $display("%0d result beats checked, %0d mismatches", results_checked,
                 mismatch_count);
        if (mismatch_count == 0)
            $display("bilinear_wrap_texture_sampler_unit verification clean");
        else
            $display("bilinear_wrap_texture_sampler_unit verification failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #800000;
        $display("Timed out with %0d results outstanding", pending_samples.size());
        $display("bilinear_wrap_texture_sampler_unit verification failed");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/bwts_pkg.sv
hdl/bwts_coord.sv
hdl/bwts_texel_store.sv
hdl/bwts_blend.sv
hdl/bilinear_wrap_texture_sampler_unit.sv
verif/bilinear_wrap_texture_sampler_unit_tb.sv
